FILE: design/fsg_pkg.sv
// Shared constants and types for the falling-sand grid stepper.
// Depends on nothing; the stepper and its testbench import it.
package fsg_pkg;

   localparam int COLS = 64;
   localparam int ROWS = 64;
   localparam int ColW = $clog2(COLS);
   localparam int RowW = $clog2(ROWS);

   localparam logic [15:0] LFSR_TAPS  = 16'hB400;
   localparam logic [15:0] SEED_RESET = 16'h0001;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_GEN   = 2'd3
   } kind_type;

   typedef logic [COLS-1:0] row_bits_type;

endpackage

FILE: design/fsg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module fsg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/falling_sand_grid_step.sv
// Falling-sand grid stepper: top level, sequencer and the shared cell-update unit.
// Depends on fsg_pkg and on fsg_ram, which holds the grid one row per word.
//
// Usage:
//  - Request channel (req_valid / req_stall): one command per transfer, with
//    req_kind (write cell, read cell, clear grid, run one generation), req_col,
//    req_row and req_cell_in. req_stall is high while a command is in work.
//  - Response channel (rsp_valid / rsp_stall): exactly one transfer per command,
//    rsp_cell_value is the cell for a read and 0 for every other kind.
//  - CSR channel (csr_valid / csr_ready): a transfer loads csr_random_seed into
//    the 16-bit LFSR; a zero seed loads 1. csr_ready is always high.
// Steps, command accepted to response presented:
//  - write or read cell: row read and modify, then response load
//  - clear grid: per-row valid flags drop at once, then response load
//  - one generation: the single cell-update unit visits one cell per cycle,
//    with a row read before each row scan and a row write-back after it.
// One command is in work at a time; the next can be taken while the response is presented.
// Reset: the grid reads as empty (per-row valid flags clear), the LFSR holds 1,
// no response is pending. The grid RAM itself needs no clearing pass.
// Response stall: a finished command waits in its last state until the response
// register is free; the response register holds its value while stalled.
module falling_sand_grid_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_kind,
   input  logic [5:0]          req_col,
   input  logic [5:0]          req_row,
   input  logic                req_cell_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_cell_value,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [15:0]         csr_random_seed
);
   import fsg_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_CELL     = 8'b0000_0010,
      S_GEN_LOW  = 8'b0000_0100,
      S_GEN_UP   = 8'b0000_1000,
      S_GEN_SCAN = 8'b0001_0000,
      S_GEN_NEXT = 8'b0010_0000,
      S_GEN_LAST = 8'b0100_0000,
      S_DONE     = 8'b1000_0000
   } state_type;

   state_type    state_ff, state_in;
   kind_type     kind_ff, kind_in;
   logic [5:0]   col_ff, col_in;
   logic [5:0]   row_ff, row_in;
   logic         cell_ff, cell_in;
   logic         res_ff, res_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_value_ff, rsp_value_in;
   logic [15:0]  lfsr_ff, lfsr_in;
   logic [RowW-1:0] y_ff, y_in;
   logic [ColW-1:0] x_ff, x_in;
   row_bits_type upper_ff, upper_in;
   row_bits_type lower_ff, lower_in;
   logic [ROWS-1:0] valid_ff, valid_in;
   logic         rd_valid_ff;

   logic            ram_we;
   logic [RowW-1:0] ram_waddr;
   row_bits_type    ram_wdata;
   logic [RowW-1:0] ram_raddr;
   row_bits_type    ram_rdata;
   row_bits_type    row_data;
   logic            in_grid;

   fsg_ram #(
      .WIDTH(COLS),
      .DEPTH(ROWS)
   ) u_grid (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // A row never written since reset or clear reads as empty.
   assign row_data = rd_valid_ff ? ram_rdata : '0;
   assign in_grid  = (int'(row_ff) < ROWS) && (int'(col_ff) < COLS);

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_value_ff;
   assign csr_ready      = 1'b1;

   // Read address: the request row on accept, otherwise the row the scan needs next.
   always_comb begin
      case (state_ff)
         S_IDLE: begin
            if (kind_type'(req_kind) == KIND_GEN) begin
               ram_raddr = RowW'(ROWS - 1);
            end else begin
               ram_raddr = RowW'(req_row);
            end
         end
         S_GEN_NEXT: ram_raddr = y_ff - RowW'(1);
         default:    ram_raddr = y_ff;
      endcase
   end

   always_comb begin
      logic            u_bit;
      logic            below;
      logic            right_free;
      logic            left_free;
      logic            draw;
      logic [ColW-1:0] xr;
      logic [ColW-1:0] xl;
      logic            x_last;

      state_in     = state_ff;
      kind_in      = kind_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cell_in      = cell_ff;
      res_in       = res_ff;
      lfsr_in      = lfsr_ff;
      y_in         = y_ff;
      x_in         = x_ff;
      upper_in     = upper_ff;
      lower_in     = lower_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      ram_we       = 1'b0;
      ram_waddr    = y_ff;
      ram_wdata    = lower_ff;

      x_last     = (x_ff == ColW'(COLS - 1));
      xr         = x_last ? x_ff : x_ff + ColW'(1);
      xl         = (x_ff == '0) ? x_ff : x_ff - ColW'(1);
      u_bit      = upper_ff[x_ff];
      below      = lower_ff[x_ff];
      right_free = !x_last && !lower_ff[xr];
      left_free  = (x_ff != '0) && !lower_ff[xl];
      draw       = lfsr_ff[0];

      // Drop the response once the receiver takes it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Load a new seed; zero would lock the LFSR up.
      if (csr_valid && csr_ready) begin
         lfsr_in = (csr_random_seed == '0) ? SEED_RESET : csr_random_seed;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in = kind_type'(req_kind);
               col_in  = req_col;
               row_in  = req_row;
               cell_in = req_cell_in;
               res_in  = 1'b0;
               case (kind_type'(req_kind))
                  KIND_WRITE, KIND_READ: state_in = S_CELL;
                  KIND_CLEAR: begin
                     valid_in = '0;
                     state_in = S_DONE;
                  end
                  default: begin
                     y_in     = RowW'(ROWS - 2);
                     state_in = S_GEN_LOW;
                  end
               endcase
            end
         end
         S_CELL: begin
            // Modify the row read on accept and write it back.
            if (in_grid) begin
               if (kind_ff == KIND_WRITE) begin
                  ram_we    = 1'b1;
                  ram_waddr = RowW'(row_ff);
                  ram_wdata = row_data;
                  ram_wdata[ColW'(col_ff)] = cell_ff;
               end else begin
                  res_in = row_data[ColW'(col_ff)];
               end
            end
            state_in = S_DONE;
         end
         S_GEN_LOW: begin
            lower_in = row_data;
            state_in = S_GEN_UP;
         end
         S_GEN_UP: begin
            upper_in = row_data;
            x_in     = '0;
            state_in = S_GEN_SCAN;
         end
         S_GEN_SCAN: begin
            // One cell per cycle, left to right, in place.
            if (u_bit) begin
               if (!below) begin
                  lower_in[x_ff] = 1'b1;
                  upper_in[x_ff] = 1'b0;
               end else begin
                  lfsr_in = (lfsr_ff >> 1) ^ (draw ? LFSR_TAPS : 16'h0000);
                  if (draw && right_free) begin
                     lower_in[xr]   = 1'b1;
                     upper_in[x_ff] = 1'b0;
                  end else if (left_free) begin
                     lower_in[xl]   = 1'b1;
                     upper_in[x_ff] = 1'b0;
                  end
               end
            end
            if (x_last) begin
               state_in = S_GEN_NEXT;
            end else begin
               x_in = x_ff + ColW'(1);
            end
         end
         S_GEN_NEXT: begin
            // Retire the lower row; the upper row becomes the next lower row.
            ram_we    = 1'b1;
            ram_waddr = y_ff + RowW'(1);
            ram_wdata = lower_ff;
            lower_in  = upper_ff;
            if (y_ff == '0) begin
               state_in = S_GEN_LAST;
            end else begin
               y_in     = y_ff - RowW'(1);
               state_in = S_GEN_UP;
            end
         end
         S_GEN_LAST: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = lower_ff;
            state_in  = S_DONE;
         end
         S_DONE: begin
            // Hold until the response register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (ram_we) begin
         valid_in[ram_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         lfsr_ff      <= SEED_RESET;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lfsr_ff      <= lfsr_in;
         valid_ff     <= valid_in;
         rd_valid_ff  <= valid_ff[ram_raddr];
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      cell_ff      <= cell_in;
      res_ff       <= res_in;
      rsp_value_ff <= rsp_value_in;
      y_ff         <= y_in;
      x_ff         <= x_in;
      upper_ff     <= upper_in;
      lower_ff     <= lower_in;
   end

   // The LFSR never reaches the all-zero lock-up state.
   a_lfsr_nonzero: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("LFSR reached zero");

   // A scan step moves grains but never creates or loses one.
   a_grains_kept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GEN_SCAN) |=>
         ($countones({upper_ff, lower_ff}) == $past($countones({upper_ff, lower_ff}))))
      else $error("grain count changed during scan");

   // The column counter advances by one per scan cycle until the last column.
   a_scan_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GEN_SCAN && x_ff != ColW'(COLS - 1)) |=>
         (state_ff == S_GEN_SCAN && x_ff == $past(x_ff) + ColW'(1)))
      else $error("scan column skipped");

   // Every row written to the grid RAM reads back as valid.
   a_row_marked: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> valid_ff[$past(ram_waddr)])
      else $error("written row not marked valid");

endmodule

FILE: sim/tb_falling_sand_grid_step.sv
// Self-checking testbench for falling_sand_grid_step: a shadow grid with its own LFSR
// predicts every response, while random idling and stalls vary the handshake timing.
// Depends on fsg_pkg and the falling_sand_grid_step RTL.
module tb_falling_sand_grid_step;
   import fsg_pkg::*;

   localparam int CLOCK_HALF     = 4;
   localparam int TIMEOUT_CYCLES = 800000;
   localparam int RANDOM_ITEMS   = 110;
   localparam int LONG_HOLD      = 120;
   localparam int DRAIN_CYCLES   = 16;

   // Shadow copy of the grid and the LFSR; predicts one cell_value per command.
   class sand_grid_shadow;
      bit          cells [ROWS][COLS];
      logic [15:0] lfsr;
      logic        read_backs [$];
      int          failures;
      int          checked;
      int          commands;
      int          generations;
      int          seed_loads;

      function new();
         wipe();
         lfsr = SEED_RESET;
      endfunction

      function void wipe();
         foreach (cells[y, x]) cells[y][x] = 1'b0;
      endfunction

      function void take_seed(logic [15:0] seed);
         lfsr = (seed == 16'd0) ? SEED_RESET : seed;
         seed_loads++;
      endfunction

      // Galois step: return the low bit, shift right, fold in the taps.
      function bit draw_coin();
         bit coin;
         coin = lfsr[0];
         lfsr = (lfsr >> 1) ^ (coin ? LFSR_TAPS : 16'd0);
         return coin;
      endfunction

      // In-place sweep, bottom-up from the second-last row, left to right.
      function void settle_generation();
         bit go_right;
         for (int y = ROWS - 2; y >= 0; y--) begin
            for (int x = 0; x < COLS; x++) begin
               if (!cells[y][x]) continue;
               if (!cells[y+1][x]) begin
                  cells[y+1][x] = 1'b1;
                  cells[y][x]   = 1'b0;
               end else begin
                  go_right = draw_coin();
                  if (x < COLS - 1 && go_right && !cells[y+1][x+1]) begin
                     cells[y+1][x+1] = 1'b1;
                     cells[y][x]     = 1'b0;
                  end else if (x >= 1 && !cells[y+1][x-1]) begin
                     cells[y+1][x-1] = 1'b1;
                     cells[y][x]     = 1'b0;
                  end
               end
            end
         end
      endfunction

      function void note_command(kind_type kind, logic [5:0] col, logic [5:0] row,
                                 logic cell_in);
         logic value;
         bit   on_grid;
         value   = 1'b0;
         on_grid = (row < ROWS) && (col < COLS);
         commands++;
         case (kind)
            KIND_WRITE: begin
               if (on_grid) cells[row][col] = cell_in;
            end
            KIND_READ: begin
               if (on_grid) value = cells[row][col];
            end
            KIND_CLEAR: begin
               wipe();
            end
            default: begin
               settle_generation();
               generations++;
            end
         endcase
         read_backs.push_back(value);
      endfunction

      function void check_cell(logic actual);
         logic wanted;
         if (read_backs.size() == 0) begin
            $error("cell_value: unexpected response, actual %0b", actual);
            failures++;
         end else begin
            wanted = read_backs.pop_front();
            checked++;
            if (actual !== wanted) begin
               $error("cell_value mismatch: expected %0b, actual %0b", wanted, actual);
               failures++;
            end
         end
      endfunction

      function int pending();
         return read_backs.size();
      endfunction
   endclass

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind        = KIND_WRITE;
   logic [5:0]  req_col         = '0;
   logic [5:0]  req_row         = '0;
   logic        req_cell_in     = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic        rsp_cell_value;
   logic        csr_valid       = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_random_seed = '0;

   sand_grid_shadow shadow = new();

   bit idling            = 1'b1;  // random gaps and stalls allowed
   bit long_hold_pending = 1'b0;  // ask the receiver for one long hold-off
   int sent_count        = 0;

   falling_sand_grid_step u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_col         (req_col),
      .req_row         (req_row),
      .req_cell_in     (req_cell_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cell_value  (rsp_cell_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_random_seed (csr_random_seed)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Watchdog: end the run if the block hangs.
   initial begin
      #(TIMEOUT_CYCLES * 2 * CLOCK_HALF);
      $display("FAILED: results differ");
      $finish;
   end

   // Observe every transfer at the clock edge; values read here are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) shadow.take_seed(csr_random_seed);
         if (req_valid && !req_stall)
            shadow.note_command(kind_type'(req_kind), req_col, req_row, req_cell_in);
         if (rsp_valid && !rsp_stall) shadow.check_cell(rsp_cell_value);
      end
   end

   // Response back-pressure: short random bursts, plus one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idling && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one command and hold it until the block takes the transfer.
   task automatic send_command(kind_type kind, logic [5:0] col, logic [5:0] row,
                               logic cell_in);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_col     <= col;
      req_row     <= row;
      req_cell_in <= cell_in;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   // Drop valid and wait until every predicted response has been taken.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (shadow.pending() != 0) @(posedge clock);
   endtask

   task automatic write_seed(logic [15:0] seed);
      wait_idle();
      csr_valid       <= 1'b1;
      csr_random_seed <= seed;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Full-range write or read somewhere on the grid.
   task automatic stray_access();
      send_command(kind_type'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                   6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
   endtask

   // Drop grains into an 8-column window near the floor, settle, then probe it.
   task automatic sand_session();
      int base;
      case ($urandom_range(0, 3))
         0:       base = 0;
         1:       base = COLS - 8;
         default: base = $urandom_range(0, COLS - 8);
      endcase
      if ($urandom_range(0, 2) == 0)
         send_command(KIND_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                      1'($urandom_range(0, 1)));
      repeat ($urandom_range(4, 10))
         send_command(KIND_WRITE, 6'(base + $urandom_range(0, 7)),
                      6'($urandom_range(ROWS - 8, ROWS - 1)), 1'($urandom_range(0, 4) != 0));
      repeat ($urandom_range(0, 2)) stray_access();
      repeat ($urandom_range(1, 2))
         send_command(KIND_GEN, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                      1'($urandom_range(0, 1)));
      repeat ($urandom_range(4, 8))
         send_command(KIND_READ, 6'(base + $urandom_range(0, 7)),
                      6'($urandom_range(ROWS - 6, ROWS - 1)), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 1)) stray_access();
   endtask

   initial begin
      int random_start;
      int session;
      logic [15:0] seed;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: corners, overwrite with 0, edge piles, then two generations on the
      // reset seed, followed by a clear.
      send_command(KIND_READ,  6'd5,  6'd5,  1'b1);
      send_command(KIND_WRITE, 6'd0,  6'd0,  1'b1);
      send_command(KIND_READ,  6'd0,  6'd0,  1'b0);
      send_command(KIND_WRITE, 6'd63, 6'd63, 1'b1);
      send_command(KIND_READ,  6'd63, 6'd63, 1'b0);
      send_command(KIND_WRITE, 6'd0,  6'd0,  1'b0);
      send_command(KIND_READ,  6'd0,  6'd0,  1'b1);
      send_command(KIND_WRITE, 6'd0,  6'd62, 1'b1);
      send_command(KIND_WRITE, 6'd0,  6'd63, 1'b1);
      send_command(KIND_WRITE, 6'd63, 6'd62, 1'b1);
      send_command(KIND_WRITE, 6'd30, 6'd62, 1'b1);
      send_command(KIND_WRITE, 6'd30, 6'd63, 1'b1);
      send_command(KIND_WRITE, 6'd31, 6'd63, 1'b1);
      send_command(KIND_WRITE, 6'd20, 6'd0,  1'b1);
      send_command(KIND_GEN,   6'd0,  6'd0,  1'b0);
      send_command(KIND_READ,  6'd1,  6'd63, 1'b0);
      send_command(KIND_READ,  6'd0,  6'd62, 1'b0);
      send_command(KIND_READ,  6'd62, 6'd63, 1'b0);
      send_command(KIND_READ,  6'd29, 6'd63, 1'b0);
      send_command(KIND_READ,  6'd20, 6'd1,  1'b0);
      send_command(KIND_GEN,   6'd63, 6'd63, 1'b1);
      send_command(KIND_READ,  6'd63, 6'd63, 1'b1);
      send_command(KIND_CLEAR, 6'd63, 6'd63, 1'b1);
      send_command(KIND_READ,  6'd63, 6'd63, 1'b0);
      send_command(KIND_READ,  6'd0,  6'd63, 1'b1);

      // Random sessions; reseed every second session, extremes first.
      random_start = sent_count;
      session      = 0;
      while (sent_count - random_start < RANDOM_ITEMS) begin
         if (session % 2 == 0) begin
            case (session / 2)
               0:       seed = 16'h0000;
               1:       seed = 16'hFFFF;
               2:       seed = 16'h8000;
               3:       seed = 16'h0001;
               default: seed = 16'($urandom_range(0, 65535));
            endcase
            write_seed(seed);
         end
         // Hold the response side off for a long stretch so the input backs up.
         if (session == 2) long_hold_pending = 1'b1;
         // Run the tail of the random part at full rate.
         if (sent_count - random_start >= RANDOM_ITEMS - 35) idling = 1'b0;
         sand_session();
         session++;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d commands, %0d generations, %0d seed loads.",
               shadow.commands, shadow.generations, shadow.seed_loads);
      $display("Compared %0d responses, with random idling and one long hold-off.",
               shadow.checked);
      if (shadow.failures == 0 && shadow.pending() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
